// ----- rtl/source_tokenizer_assert.svh -----
// ----------------------------------------------------------------------------
// Source tokenizer assertion macros
// Shorthand for clocked implication checks, reset masked.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKENIZER_ASSERT_SVH
`define SOURCE_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define ST_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication
`define ST_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

// ----- rtl/st_pkg.sv -----
// ----------------------------------------------------------------------------
// Source tokenizer package
// Scan phases, token kinds and codes, keyword table, step structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package st_pkg;

    localparam logic [3:0] K_IDENT    = 4'd0;
    localparam logic [3:0] K_KEYWORD  = 4'd1;
    localparam logic [3:0] K_INT      = 4'd2;
    localparam logic [3:0] K_FLOAT    = 4'd3;
    localparam logic [3:0] K_STRING   = 4'd4;
    localparam logic [3:0] K_OPER     = 4'd5;
    localparam logic [3:0] K_PUNCT    = 4'd6;
    localparam logic [3:0] K_EOF      = 4'd7;
    localparam logic [3:0] K_LEXERR   = 4'd8;
    localparam logic [3:0] K_OVERFLOW = 4'd9;

    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_SUB  = 5'd1;
    localparam logic [4:0] OP_MUL  = 5'd2;
    localparam logic [4:0] OP_DIV  = 5'd3;
    localparam logic [4:0] OP_IDIV = 5'd4;
    localparam logic [4:0] OP_CAT  = 5'd5;
    localparam logic [4:0] OP_LEN  = 5'd6;
    localparam logic [4:0] OP_LT   = 5'd7;
    localparam logic [4:0] OP_LE   = 5'd8;
    localparam logic [4:0] OP_GT   = 5'd9;
    localparam logic [4:0] OP_GE   = 5'd10;
    localparam logic [4:0] OP_EQ   = 5'd11;
    localparam logic [4:0] OP_NE   = 5'd12;

    localparam logic [4:0] PU_ASSIGN = 5'd0;
    localparam logic [4:0] PU_OPEN   = 5'd1;
    localparam logic [4:0] PU_CLOSE  = 5'd2;
    localparam logic [4:0] PU_COLON  = 5'd3;
    localparam logic [4:0] PU_COMMA  = 5'd4;
    localparam logic [4:0] SUB_NONE  = 5'd0;

    localparam int         KW_COUNT = 17;
    localparam logic [4:0] KW_READ  = 5'd8;
    localparam logic [4:0] KW_WRITE = 5'd13;

    localparam logic [30:0] INT_SAT  = 31'h7FFF_FFFF;
    localparam logic [15:0] LINE_SAT = 16'hFFFF;

    typedef enum logic [5:0] {
        PH_START, PH_IDENT, PH_NUM, PH_FRAC, PH_EXP_START, PH_EXP_SIGN,
        PH_EXP_DIGITS, PH_DOT, PH_DIV, PH_SUB, PH_ASSIGN, PH_LESS, PH_GREAT,
        PH_NOT, PH_LINE_CMT, PH_CMT_OPEN, PH_BLOCK, PH_BLOCK_CLOSE,
        PH_STR, PH_ESC, PH_ESC_D2, PH_ESC_D3
    } phase_t;

    typedef enum logic [1:0] {
        CT_IDLE, CT_SCAN, CT_DRAIN_RD, CT_DRAIN_WR
    } ctl_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  ch;
        logic        is_end;
        logic [30:0] acc;
        logic [7:0]  esc;
        logic [15:0] line;
        logic        cnt_full;
        logic        cnt_zero;
        logic        kw_hit;
        logic [4:0]  kw_idx;
    } step_in_t;

    typedef struct packed {
        phase_t      phase_n;
        logic        rescan;
        logic        emit;
        logic [3:0]  kind;
        logic [4:0]  sub;
        logic        drain;
        logic        drain_rescan;
        logic [30:0] ival;
        logic        app;
        logic [7:0]  app_byte;
        logic        clear_cnt;
        logic        halt;
        logic [30:0] acc_n;
        logic [7:0]  esc_n;
        logic [15:0] line_n;
    } step_out_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [4:0]  sub;
        logic [7:0]  lex_byte;
        logic [30:0] ival;
        logic [15:0] line;
        logic        last;
    } token_t;

    function automatic logic [63:0] kw_text(input logic [4:0] w);
        logic [63:0] s;
        case (w)
            5'd0:    s = "do";
            5'd1:    s = "else";
            5'd2:    s = "end";
            5'd3:    s = "function";
            5'd4:    s = "global";
            5'd5:    s = "if";
            5'd6:    s = "local";
            5'd7:    s = "nil";
            5'd8:    s = "read";
            5'd9:    s = "require";
            5'd10:   s = "return";
            5'd11:   s = "then";
            5'd12:   s = "while";
            5'd13:   s = "write";
            5'd14:   s = "integer";
            5'd15:   s = "number";
            5'd16:   s = "string";
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] kw_len(input logic [4:0] w);
        logic [3:0] n;
        case (w)
            5'd0, 5'd5:                 n = 4'd2;
            5'd2, 5'd7:                 n = 4'd3;
            5'd1, 5'd8, 5'd11:          n = 4'd4;
            5'd6, 5'd12, 5'd13:         n = 4'd5;
            5'd4, 5'd10, 5'd15, 5'd16:  n = 4'd6;
            5'd9, 5'd14:                n = 4'd7;
            5'd3:                       n = 4'd8;
            default:                    n = 4'd0;
        endcase
        return n;
    endfunction

    // character k of keyword w, zero past its end
    function automatic logic [7:0] kw_char(input logic [4:0] w, input logic [3:0] k);
        logic [63:0] s;
        logic [3:0]  n;
        logic [7:0]  r;
        s = kw_text(w);
        n = kw_len(w);
        r = '0;
        if (k < n)
        begin
            r = s[8 * (32'(n) - 1 - 32'(k)) +: 8];
        end
        return r;
    endfunction

endpackage

// ----- rtl/st_channels.sv -----
// ----------------------------------------------------------------------------
// Source tokenizer channels
// Byte input channel and token output channel, valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface st_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_end;

    modport source (output valid, char_code, is_end, input ready);
    modport sink (input valid, char_code, is_end, output ready);
endinterface

interface st_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [4:0]  sub_code;
    logic [7:0]  lexeme_byte;
    logic [30:0] int_value;
    logic [15:0] line_number;
    logic        run_last;

    modport source (output valid, token_kind, sub_code, lexeme_byte, int_value,
                    line_number, run_last, input ready);
    modport sink (input valid, token_kind, sub_code, lexeme_byte, int_value,
                  line_number, run_last, output ready);
endinterface

// ----- rtl/source_tokenizer.sv -----
// ----------------------------------------------------------------------------
// Source tokenizer
// Streaming lexer: source bytes in, tokens out, lexemes in a local RAM.
// ----------------------------------------------------------------------------
// Usage:
//   chars carries one source byte or an end mark per transaction; tokens
//   carries one result per transaction. Identifier, number and string tokens
//   come out one lexeme byte per transaction, run_last on the final byte;
//   every other token is one transaction.
//   A byte is taken when the block is idle. Each scan pass works on the held
//   byte, one to three passes per byte, and every pass waits for a free output
//   register. Each byte of a lexeme run is read from the lexeme RAM in
//   CT_DRAIN_RD and loaded into the output register in CT_DRAIN_WR. A byte that
//   only extends a lexeme takes one CT_SCAN pass, then CT_IDLE takes the next.
//   Lexical errors and lexeme overflow emit one error token; the block then
//   swallows all input until reset.
//   Reset clears scanner state and line counter; the lexeme RAM is not
//   cleared. When tokens stalls, the output register holds and the scanner
//   waits; chars is not taken until the byte is fully handled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module source_tokenizer
    import st_pkg::*;
#(
    parameter int MAX_LEXEME = 32
)
(
    input logic          clk,
    input logic          rst_n,
    st_char_if.sink      chars,
    st_token_if.source   tokens
);

    `include "source_tokenizer_assert.svh"

    localparam int AW = $clog2(MAX_LEXEME);
    localparam int CW = $clog2(MAX_LEXEME + 1);

    ctl_t            ctl_reg, ctl_next;
    phase_t          phase_reg, phase_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [30:0]     acc_reg, acc_next;
    logic [7:0]      esc_reg, esc_next;
    logic [15:0]     line_reg, line_next;
    logic            halted_reg, halted_next;
    logic [KW_COUNT-1:0] kw_mask_reg, kw_mask_next;
    logic [7:0]      ch_reg;
    logic            end_reg;
    logic [3:0]      dr_kind_reg, dr_kind_next;
    logic [30:0]     dr_ival_reg, dr_ival_next;
    logic            dr_rescan_reg, dr_rescan_next;
    logic [CW-1:0]   dr_idx_reg, dr_idx_next;
    logic            out_valid_reg, out_valid_next;
    token_t          out_reg, out_next;

    logic [7:0]      lex_mem [MAX_LEXEME];
    logic [7:0]      rd_data_reg;

    step_in_t        si;
    step_out_t       so;

    logic            accept;
    logic            slot_free;
    logic            pass_go;
    logic            mem_we;
    logic [CW-1:0]   app_idx;
    logic            kw_hit;
    logic [4:0]      kw_idx;
    logic            dr_last;
    logic            out_load;

    assign accept    = chars.valid && chars.ready;
    assign slot_free = !out_valid_reg || tokens.ready;
    assign pass_go   = (ctl_reg == CT_SCAN) && slot_free;
    assign app_idx   = so.clear_cnt ? '0 : cnt_reg;
    assign mem_we    = pass_go && so.app;
    assign dr_last   = (dr_idx_reg + CW'(1)) == cnt_reg;

    // keyword lookup: candidates whose length equals the lexeme length, read and write excluded
    always_comb
    begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int w = KW_COUNT - 1; w >= 0; w--)
        begin
            if (kw_mask_reg[w] && CW'(kw_len(5'(w))) == cnt_reg
                && 5'(w) != KW_READ && 5'(w) != KW_WRITE)
            begin
                kw_hit = 1'b1;
                kw_idx = 5'(w);
            end
        end
    end

    always_comb
    begin
        si.phase    = phase_reg;
        si.ch       = ch_reg;
        si.is_end   = end_reg;
        si.acc      = acc_reg;
        si.esc      = esc_reg;
        si.line     = line_reg;
        si.cnt_full = cnt_reg >= CW'(MAX_LEXEME);
        si.cnt_zero = cnt_reg == '0;
        si.kw_hit   = kw_hit;
        si.kw_idx   = kw_idx;
    end

    st_scan_step u_step
    (
        .si (si),
        .so (so)
    );

    // control next state
    always_comb
    begin
        ctl_next = ctl_reg;
        case (ctl_reg)
            CT_IDLE:
            begin
                if (accept && !halted_reg)
                begin
                    ctl_next = CT_SCAN;
                end
            end
            CT_SCAN:
            begin
                if (pass_go)
                begin
                    if (so.halt)
                    begin
                        ctl_next = CT_IDLE;
                    end
                    else if (so.drain)
                    begin
                        ctl_next = CT_DRAIN_RD;
                    end
                    else if (!so.rescan)
                    begin
                        ctl_next = CT_IDLE;
                    end
                end
            end
            CT_DRAIN_RD:
            begin
                ctl_next = CT_DRAIN_WR;
            end
            CT_DRAIN_WR:
            begin
                if (slot_free)
                begin
                    if (!dr_last)
                    begin
                        ctl_next = CT_DRAIN_RD;
                    end
                    else if (dr_rescan_reg)
                    begin
                        ctl_next = CT_SCAN;
                    end
                    else
                    begin
                        ctl_next = CT_IDLE;
                    end
                end
            end
            default:
            begin
                ctl_next = CT_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        esc_next       = esc_reg;
        line_next      = line_reg;
        halted_next    = halted_reg;
        kw_mask_next   = kw_mask_reg;
        dr_kind_next   = dr_kind_reg;
        dr_ival_next   = dr_ival_reg;
        dr_rescan_next = dr_rescan_reg;
        dr_idx_next    = dr_idx_reg;
        out_next       = out_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !tokens.ready;
        chars.ready    = ctl_reg == CT_IDLE;

        if (pass_go)
        begin
            phase_next  = so.phase_n;
            acc_next    = so.acc_n;
            esc_next    = so.esc_n;
            line_next   = so.line_n;
            halted_next = halted_reg || so.halt;
            if (so.clear_cnt)
            begin
                cnt_next = '0;
            end
            if (so.app)
            begin
                cnt_next = app_idx + CW'(1);
                for (int w = 0; w < KW_COUNT; w++)
                begin
                    kw_mask_next[w] = (so.clear_cnt || kw_mask_reg[w]) && app_idx < CW'(8)
                                      && kw_char(5'(w), 4'(app_idx)) == so.app_byte;
                end
            end
            if (so.emit)
            begin
                out_load          = 1'b1;
                out_next.kind     = so.kind;
                out_next.sub      = so.sub;
                out_next.lex_byte = '0;
                out_next.ival     = '0;
                out_next.line     = so.line_n;
                out_next.last     = 1'b1;
            end
            if (so.drain)
            begin
                dr_kind_next   = so.kind;
                dr_ival_next   = so.ival;
                dr_rescan_next = so.drain_rescan;
                dr_idx_next    = '0;
            end
        end

        if (ctl_reg == CT_DRAIN_WR && slot_free)
        begin
            out_load          = 1'b1;
            out_next.kind     = dr_kind_reg;
            out_next.sub      = SUB_NONE;
            out_next.lex_byte = rd_data_reg;
            out_next.ival     = dr_ival_reg;
            out_next.line     = line_reg;
            out_next.last     = dr_last;
            dr_idx_next       = dr_idx_reg + CW'(1);
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= CT_IDLE;
            phase_reg     <= PH_START;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            esc_reg       <= '0;
            line_reg      <= '0;
            halted_reg    <= 1'b0;
            kw_mask_reg   <= '0;
            dr_rescan_reg <= 1'b0;
            dr_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ctl_reg       <= ctl_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            esc_reg       <= esc_next;
            line_reg      <= line_next;
            halted_reg    <= halted_next;
            kw_mask_reg   <= kw_mask_next;
            dr_rescan_reg <= dr_rescan_next;
            dr_idx_reg    <= dr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= chars.char_code;
            end_reg <= chars.is_end;
        end
        dr_kind_reg <= dr_kind_next;
        dr_ival_reg <= dr_ival_next;
        out_reg     <= out_next;
    end

    // lexeme RAM: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lex_mem[app_idx[AW-1:0]] <= so.app_byte;
        end
        if (ctl_reg == CT_DRAIN_RD)
        begin
            rd_data_reg <= lex_mem[dr_idx_reg[AW-1:0]];
        end
    end

    assign tokens.valid       = out_valid_reg;
    assign tokens.token_kind  = out_reg.kind;
    assign tokens.sub_code    = out_reg.sub;
    assign tokens.lexeme_byte = out_reg.lex_byte;
    assign tokens.int_value   = out_reg.ival;
    assign tokens.line_number = out_reg.line;
    assign tokens.run_last    = out_reg.last;

    `ST_ASSERT_IMP(a_load_into_free_slot, out_load, !out_valid_reg || tokens.ready)
    `ST_ASSERT_IMP(a_drain_in_range, ctl_reg == CT_DRAIN_WR, dr_idx_reg < cnt_reg)
    `ST_ASSERT_IMP(a_halted_idle, halted_reg, ctl_reg == CT_IDLE)
    `ST_ASSERT_NEXT(a_halt_silences, halted_reg, !out_load)

endmodule

// ----- rtl/st_scan_step.sv -----
// ----------------------------------------------------------------------------
// Source tokenizer scan step
// One pass of the scanner over the held byte: next phase and side effects.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module st_scan_step
    import st_pkg::*;
(
    input  step_in_t  si,
    output step_out_t so
);

    logic        e;
    logic [7:0]  c;
    logic        dig;
    logic        expo;
    logic        word;
    logic        ws;
    logic [3:0]  dval;
    logic [34:0] acc10;
    logic [7:0]  esc10;

    assign e     = si.is_end;
    assign c     = si.ch;
    assign dig   = !e && c >= "0" && c <= "9";
    assign expo  = !e && (c == "e" || c == "E");
    assign word  = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_"
                   || (c >= "0" && c <= "9");
    assign ws    = c == " " || c == 8'd9 || c == 8'd10 || c == 8'd11
                   || c == 8'd12 || c == 8'd13;
    assign dval  = 4'(c - "0");
    assign acc10 = ({4'b0, si.acc} << 3) + ({4'b0, si.acc} << 1) + 35'(dval);
    assign esc10 = (si.esc << 3) + (si.esc << 1) + {4'b0, dval};

    always_comb
    begin
        so              = '0;
        so.phase_n      = si.phase;
        so.acc_n        = si.acc;
        so.esc_n        = si.esc;
        so.line_n       = si.line;
        so.app_byte     = c;

        case (si.phase)
            PH_START:
            begin
                if (e)
                begin
                    so.emit = 1'b1;
                    so.kind = K_EOF;
                end
                else if (ws)
                begin
                    if (c == 8'd10 && si.line != LINE_SAT)
                    begin
                        so.line_n = si.line + 16'd1;
                    end
                end
                else if (word)
                begin
                    so.clear_cnt = 1'b1;
                    so.app       = 1'b1;
                    if (c >= "0" && c <= "9")
                    begin
                        so.acc_n   = {27'b0, dval};
                        so.phase_n = PH_NUM;
                    end
                    else
                    begin
                        so.phase_n = PH_IDENT;
                    end
                end
                else
                begin
                    case (c)
                        ".":      so.phase_n = PH_DOT;
                        "-":      so.phase_n = PH_SUB;
                        "/":      so.phase_n = PH_DIV;
                        "=":      so.phase_n = PH_ASSIGN;
                        "<":      so.phase_n = PH_LESS;
                        ">":      so.phase_n = PH_GREAT;
                        "~":      so.phase_n = PH_NOT;
                        "\"":
                        begin
                            so.clear_cnt = 1'b1;
                            so.phase_n   = PH_STR;
                        end
                        "+":      begin so.emit = 1'b1; so.kind = K_OPER; so.sub = OP_ADD; end
                        "*":      begin so.emit = 1'b1; so.kind = K_OPER; so.sub = OP_MUL; end
                        "#":      begin so.emit = 1'b1; so.kind = K_OPER; so.sub = OP_LEN; end
                        "(", "[": begin so.emit = 1'b1; so.kind = K_PUNCT; so.sub = PU_OPEN; end
                        ")", "]": begin so.emit = 1'b1; so.kind = K_PUNCT; so.sub = PU_CLOSE; end
                        ":":      begin so.emit = 1'b1; so.kind = K_PUNCT; so.sub = PU_COLON; end
                        ",":      begin so.emit = 1'b1; so.kind = K_PUNCT; so.sub = PU_COMMA; end
                        default:
                        begin
                            so.emit = 1'b1;
                            so.kind = K_LEXERR;
                            so.halt = 1'b1;
                        end
                    endcase
                end
            end

            PH_IDENT:
            begin
                if (!e && word)
                begin
                    so.app = 1'b1;
                end
                else
                begin
                    so.phase_n = PH_START;
                    if (si.kw_hit)
                    begin
                        so.emit   = 1'b1;
                        so.kind   = K_KEYWORD;
                        so.sub    = si.kw_idx;
                        so.rescan = 1'b1;
                    end
                    else
                    begin
                        so.drain        = 1'b1;
                        so.kind         = K_IDENT;
                        so.drain_rescan = 1'b1;
                    end
                end
            end

            PH_NUM:
            begin
                if (dig)
                begin
                    so.acc_n = (acc10 > 35'(INT_SAT)) ? INT_SAT : acc10[30:0];
                    so.app   = 1'b1;
                end
                else if (expo)
                begin
                    so.app     = 1'b1;
                    so.phase_n = PH_EXP_START;
                end
                else if (!e && c == ".")
                begin
                    so.app     = 1'b1;
                    so.phase_n = PH_FRAC;
                end
                else
                begin
                    so.drain        = 1'b1;
                    so.kind         = K_INT;
                    so.ival         = si.acc;
                    so.drain_rescan = 1'b1;
                    so.phase_n      = PH_START;
                end
            end

            PH_FRAC, PH_EXP_DIGITS:
            begin
                if (dig)
                begin
                    so.app = 1'b1;
                end
                else if (expo && si.phase == PH_FRAC)
                begin
                    so.app     = 1'b1;
                    so.phase_n = PH_EXP_START;
                end
                else
                begin
                    so.drain        = 1'b1;
                    so.kind         = K_FLOAT;
                    so.drain_rescan = 1'b1;
                    so.phase_n      = PH_START;
                end
            end

            PH_EXP_START, PH_EXP_SIGN:
            begin
                if (si.phase == PH_EXP_START && !e && (c == "+" || c == "-"))
                begin
                    so.app     = 1'b1;
                    so.phase_n = PH_EXP_SIGN;
                end
                else if (dig)
                begin
                    so.app     = 1'b1;
                    so.phase_n = PH_EXP_DIGITS;
                end
                else
                begin
                    so.emit = 1'b1;
                    so.kind = K_LEXERR;
                    so.halt = 1'b1;
                end
            end

            PH_DOT, PH_NOT:
            begin
                so.emit = 1'b1;
                if (si.phase == PH_DOT && !e && c == ".")
                begin
                    so.kind    = K_OPER;
                    so.sub     = OP_CAT;
                    so.phase_n = PH_START;
                end
                else if (si.phase == PH_NOT && !e && c == "=")
                begin
                    so.kind    = K_OPER;
                    so.sub     = OP_NE;
                    so.phase_n = PH_START;
                end
                else
                begin
                    so.kind = K_LEXERR;
                    so.halt = 1'b1;
                end
            end

            PH_DIV:
            begin
                so.emit    = 1'b1;
                so.kind    = K_OPER;
                so.phase_n = PH_START;
                if (!e && c == "/")
                begin
                    so.sub = OP_IDIV;
                end
                else
                begin
                    so.sub    = OP_DIV;
                    so.rescan = 1'b1;
                end
            end

            PH_ASSIGN, PH_LESS, PH_GREAT:
            begin
                so.emit    = 1'b1;
                so.kind    = K_OPER;
                so.phase_n = PH_START;
                if (!e && c == "=")
                begin
                    so.sub = (si.phase == PH_ASSIGN) ? OP_EQ :
                             (si.phase == PH_LESS) ? OP_LE : OP_GE;
                end
                else
                begin
                    so.rescan = 1'b1;
                    if (si.phase == PH_ASSIGN)
                    begin
                        so.kind = K_PUNCT;
                        so.sub  = PU_ASSIGN;
                    end
                    else
                    begin
                        so.sub = (si.phase == PH_LESS) ? OP_LT : OP_GT;
                    end
                end
            end

            PH_SUB:
            begin
                if (!e && c == "-")
                begin
                    so.phase_n = PH_LINE_CMT;
                end
                else
                begin
                    so.emit    = 1'b1;
                    so.kind    = K_OPER;
                    so.sub     = OP_SUB;
                    so.phase_n = PH_START;
                    so.rescan  = 1'b1;
                end
            end

            PH_LINE_CMT:
            begin
                if (e)
                begin
                    so.phase_n = PH_START;
                    so.rescan  = 1'b1;
                end
                else if (c == 8'd10)
                begin
                    so.phase_n = PH_START;
                    if (si.line != LINE_SAT)
                    begin
                        so.line_n = si.line + 16'd1;
                    end
                end
                else if (c == "[")
                begin
                    so.phase_n = PH_CMT_OPEN;
                end
            end

            PH_CMT_OPEN:
            begin
                if (!e && c == "[")
                begin
                    so.phase_n = PH_BLOCK;
                end
                else
                begin
                    so.phase_n = PH_LINE_CMT;
                    so.rescan  = 1'b1;
                end
            end

            PH_BLOCK:
            begin
                if (e)
                begin
                    so.emit = 1'b1;
                    so.kind = K_LEXERR;
                    so.halt = 1'b1;
                end
                else if (c == "]")
                begin
                    so.phase_n = PH_BLOCK_CLOSE;
                end
                else if (c == 8'd10 && si.line != LINE_SAT)
                begin
                    so.line_n = si.line + 16'd1;
                end
            end

            PH_BLOCK_CLOSE:
            begin
                if (!e && c == "]")
                begin
                    so.phase_n = PH_START;
                end
                else
                begin
                    so.phase_n = PH_BLOCK;
                    so.rescan  = 1'b1;
                end
            end

            PH_STR:
            begin
                if (e)
                begin
                    so.emit = 1'b1;
                    so.kind = K_LEXERR;
                    so.halt = 1'b1;
                end
                else if (c == "\"")
                begin
                    so.phase_n = PH_START;
                    so.kind    = K_STRING;
                    // empty string is a single transaction with a zero byte
                    so.emit    = si.cnt_zero;
                    so.drain   = !si.cnt_zero;
                end
                else if (c == "\\")
                begin
                    so.phase_n = PH_ESC;
                end
                else if (c < 8'd32)
                begin
                    if (c == 8'd10 && si.line != LINE_SAT)
                    begin
                        so.line_n = si.line + 16'd1;
                    end
                    so.emit = 1'b1;
                    so.kind = K_LEXERR;
                    so.halt = 1'b1;
                end
                else
                begin
                    so.app = 1'b1;
                end
            end

            PH_ESC:
            begin
                if (!e && c >= "0" && c <= "2")
                begin
                    so.esc_n   = {4'b0, dval};
                    so.phase_n = PH_ESC_D2;
                end
                else if (!e && (c == "n" || c == "t" || c == "\"" || c == "\\"))
                begin
                    so.app      = 1'b1;
                    so.app_byte = (c == "n") ? 8'd10 : ((c == "t") ? 8'd9 : c);
                    so.phase_n  = PH_STR;
                end
                else
                begin
                    so.emit = 1'b1;
                    so.kind = K_LEXERR;
                    so.halt = 1'b1;
                end
            end

            PH_ESC_D2:
            begin
                if (dig && (si.esc < 8'd2 || c <= "5"))
                begin
                    so.esc_n   = esc10;
                    so.phase_n = PH_ESC_D3;
                end
                else
                begin
                    so.emit = 1'b1;
                    so.kind = K_LEXERR;
                    so.halt = 1'b1;
                end
            end

            PH_ESC_D3:
            begin
                if (dig && (si.esc != 8'd0 || c != "0") && (si.esc != 8'd25 || c <= "5"))
                begin
                    so.app      = 1'b1;
                    so.app_byte = esc10;
                    so.phase_n  = PH_STR;
                end
                else
                begin
                    so.emit = 1'b1;
                    so.kind = K_LEXERR;
                    so.halt = 1'b1;
                end
            end

            default:
            begin
                so.phase_n = PH_START;
            end
        endcase

        // appending to a full lexeme buffer
        if (so.app && si.cnt_full && !so.clear_cnt)
        begin
            so.app     = 1'b0;
            so.emit    = 1'b1;
            so.kind    = K_OVERFLOW;
            so.sub     = SUB_NONE;
            so.drain   = 1'b0;
            so.rescan  = 1'b0;
            so.halt    = 1'b1;
        end

        if (so.halt)
        begin
            so.phase_n = PH_START;
        end
    end

endmodule

// ----- test/tb_source_tokenizer.sv -----
// ----------------------------------------------------------------------------
// Source tokenizer testbench
// Feeds byte streams of well-formed tokens with random gaps on both channels,
// predicts every token, and ends on one deliberate error to check the halt.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_source_tokenizer;
    import st_pkg::*;

    localparam int LEX_DEPTH   = 32;
    localparam int IDLE_PCT    = 22;
    localparam int STALL_LIMIT = 4000;
    localparam int ITEM_GOAL   = 320;

    typedef struct {
        logic [7:0] ch;
        bit         e;
    } src_t;

    typedef struct {
        logic [7:0] ch;
        bit         e;
        bit         typed;
        token_t     tok;
    } row_t;

    logic clk;
    logic rst_n;

    st_char_if  cv();
    st_token_if tv();

    source_tokenizer #(.MAX_LEXEME(LEX_DEPTH)) u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (cv),
        .tokens (tv)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // scanner state of the predictor
    phase_t      ph;
    logic [7:0]  lex_mem [LEX_DEPTH];
    int          lex_cnt;
    logic [30:0] num_acc;
    int          esc_acc;
    logic [15:0] lines_seen;
    bit          halted;

    token_t step_q[$];
    token_t token_q[$];
    src_t   src_q[$];
    row_t   rows[$];

    int errors;
    int items_sent;
    int stall_cnt;
    int cycle_cnt;
    bit tx_accept;

    string kw_words[KW_COUNT] = '{"do", "else", "end", "function", "global", "if",
        "local", "nil", "read", "require", "return", "then", "while", "write",
        "integer", "number", "string"};

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_wordch(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || is_dig(c);
    endfunction

    function automatic void put(logic [3:0] k, logic [4:0] s, logic [7:0] b,
                                logic [30:0] v, bit l);
        token_t t;
        t.kind = k;
        t.sub = s;
        t.lex_byte = b;
        t.ival = v;
        t.line = lines_seen;
        t.last = l;
        step_q.push_back(t);
    endfunction

    function automatic void halt_on(logic [3:0] k);
        put(k, SUB_NONE, 8'd0, 31'd0, 1'b1);
        halted = 1'b1;
        ph = PH_START;
    endfunction

    function automatic void bump_line();
        if (lines_seen != LINE_SAT)
        begin
            lines_seen++;
        end
    endfunction

    function automatic bit add_byte(logic [7:0] b);
        if (lex_cnt >= LEX_DEPTH)
        begin
            halt_on(K_OVERFLOW);
            return 1'b0;
        end
        lex_mem[lex_cnt] = b;
        lex_cnt++;
        return 1'b1;
    endfunction

    function automatic void put_run(logic [3:0] k, logic [30:0] v);
        if (lex_cnt == 0)
        begin
            put(k, SUB_NONE, 8'd0, v, 1'b1);
            return;
        end
        for (int i = 0; i < lex_cnt; i++)
        begin
            put(k, SUB_NONE, lex_mem[i], v, i + 1 == lex_cnt);
        end
    endfunction

    function automatic void close_word();
        int hit;
        bit same;
        hit = -1;
        for (int w = 0; w < KW_COUNT; w++)
        begin
            if (kw_words[w].len() == lex_cnt && hit < 0)
            begin
                same = 1'b1;
                for (int i = 0; i < lex_cnt; i++)
                begin
                    if (lex_mem[i] != kw_words[w][i])
                    begin
                        same = 1'b0;
                    end
                end
                if (same)
                begin
                    hit = w;
                end
            end
        end
        if (hit >= 0 && hit != int'(KW_READ) && hit != int'(KW_WRITE))
        begin
            put(K_KEYWORD, 5'(hit), 8'd0, 31'd0, 1'b1);
        end
        else
        begin
            put_run(K_IDENT, 31'd0);
        end
    endfunction

    // two-byte operator: returns 1 when the byte must be scanned again
    function automatic bit pair(logic [7:0] c, bit e, logic [7:0] second,
                                logic [3:0] k_short, logic [4:0] c_short,
                                logic [4:0] c_long);
        ph = PH_START;
        if (!e && c == second)
        begin
            put(K_OPER, c_long, 8'd0, 31'd0, 1'b1);
            return 1'b0;
        end
        put(k_short, c_short, 8'd0, 31'd0, 1'b1);
        return 1'b1;
    endfunction

    function automatic void scan_start(logic [7:0] c, bit e);
        bit ok;
        if (e)
        begin
            put(K_EOF, SUB_NONE, 8'd0, 31'd0, 1'b1);
            return;
        end
        if (c == " " || c == 8'd9 || c == 8'd10 || c == 8'd11 || c == 8'd12 || c == 8'd13)
        begin
            if (c == 8'd10)
            begin
                bump_line();
            end
            return;
        end
        if (is_wordch(c))
        begin
            lex_cnt = 0;
            if (is_dig(c))
            begin
                num_acc = 31'(c - "0");
                ph = PH_NUM;
            end
            else
            begin
                ph = PH_IDENT;
            end
            ok = add_byte(c);
            return;
        end
        case (c)
            ".": ph = PH_DOT;
            "+": put(K_OPER, OP_ADD, 8'd0, 31'd0, 1'b1);
            "-": ph = PH_SUB;
            "*": put(K_OPER, OP_MUL, 8'd0, 31'd0, 1'b1);
            "/": ph = PH_DIV;
            "#": put(K_OPER, OP_LEN, 8'd0, 31'd0, 1'b1);
            "=": ph = PH_ASSIGN;
            "<": ph = PH_LESS;
            ">": ph = PH_GREAT;
            "~": ph = PH_NOT;
            "\"":
            begin
                lex_cnt = 0;
                ph = PH_STR;
            end
            "(", "[": put(K_PUNCT, PU_OPEN, 8'd0, 31'd0, 1'b1);
            ")", "]": put(K_PUNCT, PU_CLOSE, 8'd0, 31'd0, 1'b1);
            ":": put(K_PUNCT, PU_COLON, 8'd0, 31'd0, 1'b1);
            ",": put(K_PUNCT, PU_COMMA, 8'd0, 31'd0, 1'b1);
            default: halt_on(K_LEXERR);
        endcase
    endfunction

    // one pass over the byte; 1 means scan it again from the new phase
    function automatic bit scan(logic [7:0] c, bit e);
        bit     dig;
        bit     expo;
        bit     ok;
        longint v;
        dig = !e && is_dig(c);
        expo = !e && (c == "e" || c == "E");
        case (ph)
            PH_IDENT:
            begin
                if (!e && is_wordch(c))
                begin
                    ok = add_byte(c);
                    return 1'b0;
                end
                close_word();
                ph = PH_START;
                return 1'b1;
            end
            PH_NUM:
            begin
                if (dig)
                begin
                    v = longint'(num_acc) * 10 + longint'(c - "0");
                    num_acc = v > longint'(INT_SAT) ? INT_SAT : 31'(v);
                    ok = add_byte(c);
                    return 1'b0;
                end
                if (expo || (!e && c == "."))
                begin
                    if (add_byte(c))
                    begin
                        ph = expo ? PH_EXP_START : PH_FRAC;
                    end
                    return 1'b0;
                end
                put_run(K_INT, num_acc);
                ph = PH_START;
                return 1'b1;
            end
            PH_FRAC:
            begin
                if (dig)
                begin
                    ok = add_byte(c);
                    return 1'b0;
                end
                if (expo)
                begin
                    if (add_byte(c))
                    begin
                        ph = PH_EXP_START;
                    end
                    return 1'b0;
                end
                put_run(K_FLOAT, 31'd0);
                ph = PH_START;
                return 1'b1;
            end
            PH_EXP_START, PH_EXP_SIGN:
            begin
                if (ph == PH_EXP_START && !e && (c == "+" || c == "-"))
                begin
                    if (add_byte(c))
                    begin
                        ph = PH_EXP_SIGN;
                    end
                end
                else if (dig)
                begin
                    if (add_byte(c))
                    begin
                        ph = PH_EXP_DIGITS;
                    end
                end
                else
                begin
                    halt_on(K_LEXERR);
                end
                return 1'b0;
            end
            PH_EXP_DIGITS:
            begin
                if (dig)
                begin
                    ok = add_byte(c);
                    return 1'b0;
                end
                put_run(K_FLOAT, 31'd0);
                ph = PH_START;
                return 1'b1;
            end
            PH_DOT, PH_NOT:
            begin
                if (!e && c == (ph == PH_DOT ? 8'h2e : 8'h3d))
                begin
                    put(K_OPER, ph == PH_DOT ? OP_CAT : OP_NE, 8'd0, 31'd0, 1'b1);
                    ph = PH_START;
                end
                else
                begin
                    halt_on(K_LEXERR);
                end
                return 1'b0;
            end
            PH_DIV:    return pair(c, e, "/", K_OPER, OP_DIV, OP_IDIV);
            PH_ASSIGN: return pair(c, e, "=", K_PUNCT, PU_ASSIGN, OP_EQ);
            PH_LESS:   return pair(c, e, "=", K_OPER, OP_LT, OP_LE);
            PH_GREAT:  return pair(c, e, "=", K_OPER, OP_GT, OP_GE);
            PH_SUB:
            begin
                if (!e && c == "-")
                begin
                    ph = PH_LINE_CMT;
                    return 1'b0;
                end
                put(K_OPER, OP_SUB, 8'd0, 31'd0, 1'b1);
                ph = PH_START;
                return 1'b1;
            end
            PH_LINE_CMT:
            begin
                if (e)
                begin
                    ph = PH_START;
                    return 1'b1;
                end
                if (c == 8'd10)
                begin
                    bump_line();
                    ph = PH_START;
                end
                else if (c == "[")
                begin
                    ph = PH_CMT_OPEN;
                end
                return 1'b0;
            end
            PH_CMT_OPEN:
            begin
                if (!e && c == "[")
                begin
                    ph = PH_BLOCK;
                    return 1'b0;
                end
                ph = PH_LINE_CMT;
                return 1'b1;
            end
            PH_BLOCK:
            begin
                if (e)
                begin
                    halt_on(K_LEXERR);
                end
                else if (c == "]")
                begin
                    ph = PH_BLOCK_CLOSE;
                end
                else if (c == 8'd10)
                begin
                    bump_line();
                end
                return 1'b0;
            end
            PH_BLOCK_CLOSE:
            begin
                if (!e && c == "]")
                begin
                    ph = PH_START;
                    return 1'b0;
                end
                ph = PH_BLOCK;
                return 1'b1;
            end
            PH_STR:
            begin
                if (e)
                begin
                    halt_on(K_LEXERR);
                end
                else if (c == "\"")
                begin
                    put_run(K_STRING, 31'd0);
                    ph = PH_START;
                end
                else if (c == "\\")
                begin
                    ph = PH_ESC;
                end
                else if (c < 8'd32)
                begin
                    if (c == 8'd10)
                    begin
                        bump_line();
                    end
                    halt_on(K_LEXERR);
                end
                else
                begin
                    ok = add_byte(c);
                end
                return 1'b0;
            end
            PH_ESC:
            begin
                if (!e && c >= "0" && c <= "2")
                begin
                    esc_acc = c - "0";
                    ph = PH_ESC_D2;
                end
                else if (!e && (c == "n" || c == "t" || c == "\"" || c == "\\"))
                begin
                    if (add_byte(c == "n" ? 8'd10 : (c == "t" ? 8'd9 : c)))
                    begin
                        ph = PH_STR;
                    end
                end
                else
                begin
                    halt_on(K_LEXERR);
                end
                return 1'b0;
            end
            PH_ESC_D2:
            begin
                if (dig && (esc_acc < 2 || c <= "5"))
                begin
                    esc_acc = (esc_acc * 10 + (c - "0")) & 255;
                    ph = PH_ESC_D3;
                end
                else
                begin
                    halt_on(K_LEXERR);
                end
                return 1'b0;
            end
            PH_ESC_D3:
            begin
                if (dig && (esc_acc != 0 || c != "0") && (esc_acc != 25 || c <= "5"))
                begin
                    if (add_byte(8'((esc_acc * 10 + (c - "0")) & 255)))
                    begin
                        ph = PH_STR;
                    end
                end
                else
                begin
                    halt_on(K_LEXERR);
                end
                return 1'b0;
            end
            default:
            begin
                ph = PH_START;
                scan_start(c, e);
                return 1'b0;
            end
        endcase
    endfunction

    // tokens caused by one accepted byte land in step_q
    function automatic void predict_tokens(logic [7:0] c, bit e);
        step_q.delete();
        if (halted)
        begin
            return;
        end
        for (int p = 0; p < 4 && !halted; p++)
        begin
            if (!scan(c, e))
            begin
                break;
            end
        end
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send_byte(logic [7:0] c, bit e, bit typed, token_t tok);
        while ($urandom_range(99) < IDLE_PCT && !(items_sent >= 120 && items_sent < 200))
        begin
            cv.valid <= 1'b0;
            @(posedge clk);
        end
        cv.valid <= 1'b1;
        cv.char_code <= c;
        cv.is_end <= e;
        do
        begin
            @(posedge clk);
        end
        while (!cv.ready);
        predict_tokens(c, e);
        if (typed)
        begin
            token_q.push_back(tok);
        end
        else
        begin
            foreach (step_q[i])
            begin
                token_q.push_back(step_q[i]);
            end
        end
        items_sent++;
    endtask

    task automatic flush_src();
        token_t none;
        none = '0;
        while (src_q.size() > 0)
        begin
            src_t s;
            s = src_q.pop_front();
            if (items_sent == 200)
            begin
                // hold off until the token side has fully drained
                cv.valid <= 1'b0;
                do
                begin
                    @(posedge clk);
                end
                while (token_q.size() != 0);
            end
            send_byte(s.ch, s.e, 1'b0, none);
        end
    endtask

    function automatic void push_ch(logic [7:0] c);
        src_t s;
        s.ch = c;
        s.e = 1'b0;
        src_q.push_back(s);
    endfunction

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_ch(s[i]);
        end
    endfunction

    function automatic void push_digits(int n);
        for (int i = 0; i < n; i++)
        begin
            push_ch(8'("0" + $urandom_range(9)));
        end
    endfunction

    function automatic logic [7:0] rand_wordch();
        case ($urandom_range(3))
            0:       return 8'("a" + $urandom_range(25));
            1:       return 8'("A" + $urandom_range(25));
            2:       return 8'("0" + $urandom_range(9));
            default: return "_";
        endcase
    endfunction

    function automatic void gen_ident(int n);
        push_ch($urandom_range(1) ? 8'("a" + $urandom_range(25)) : "_");
        for (int i = 1; i < n; i++)
        begin
            push_ch(rand_wordch());
        end
    endfunction

    function automatic void gen_string();
        int n;
        int v;
        logic [7:0] b;
        n = $urandom_range(30);
        push_ch("\"");
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(5))
                0:
                begin
                    push_ch("\\");
                    case ($urandom_range(3))
                        0:       push_ch("n");
                        1:       push_ch("t");
                        2:       push_ch("\"");
                        default: push_ch("\\");
                    endcase
                end
                1:
                begin
                    v = $urandom_range(1, 255);
                    push_ch("\\");
                    push_ch(8'("0" + v / 100));
                    push_ch(8'("0" + (v / 10) % 10));
                    push_ch(8'("0" + v % 10));
                end
                default:
                begin
                    do
                    begin
                        b = 8'($urandom_range(32, 255));
                    end
                    while (b == "\"" || b == "\\");
                    push_ch(b);
                end
            endcase
        end
        push_ch("\"");
    endfunction

    // one well-formed token or comment, then a whitespace separator
    function automatic void gen_token();
        string ops[21] = '{"+", "-", "*", "/", "//", "..", "#", "<", "<=", ">", ">=",
            "==", "~=", "=", "(", "[", ")", "]", ":", ",", "~="};
        logic [7:0] seps[4] = '{8'd32, 8'd9, 8'd10, 8'd13};
        logic [7:0] b;
        src_t s;
        case ($urandom_range(11))
            0, 1: gen_ident($urandom_range(9) == 0 ? LEX_DEPTH : $urandom_range(1, 8));
            2:    push_str(kw_words[$urandom_range(KW_COUNT - 1)]);
            3:    push_digits($urandom_range(1, 12));
            4:
            begin
                push_digits($urandom_range(1, 5));
                push_ch(".");
                push_digits($urandom_range(0, 4));
                if ($urandom_range(1))
                begin
                    push_ch($urandom_range(1) ? "e" : "E");
                    if ($urandom_range(1))
                    begin
                        push_ch($urandom_range(1) ? "+" : "-");
                    end
                    push_digits($urandom_range(1, 3));
                end
            end
            5:
            begin
                push_digits($urandom_range(1, 4));
                push_ch("e");
                push_digits($urandom_range(1, 3));
            end
            6:    gen_string();
            7, 8: push_str(ops[$urandom_range(20)]);
            9:
            begin
                push_str("--");
                if ($urandom_range(1))
                begin
                    push_str("[[");
                    repeat ($urandom_range(12))
                    begin
                        do
                        begin
                            b = 8'($urandom_range(255));
                        end
                        while (b == "]");
                        push_ch(b);
                    end
                    push_str("]]");
                end
                else
                begin
                    repeat ($urandom_range(10))
                    begin
                        do
                        begin
                            b = 8'($urandom_range(255));
                        end
                        while (b == 8'd10 || b == "[");
                        push_ch(b);
                    end
                    push_ch(8'd10);
                end
            end
            10:
            begin
                s.ch = 8'($urandom_range(255));
                s.e = 1'b1;
                src_q.push_back(s);
            end
            default: push_ch(8'($urandom_range(9, 13)));
        endcase
        push_ch(seps[$urandom_range(3)]);
    endfunction

    function automatic token_t tk(logic [3:0] k, logic [4:0] s, logic [15:0] ln);
        token_t t;
        t = '0;
        t.kind = k;
        t.sub = s;
        t.line = ln;
        t.last = 1'b1;
        return t;
    endfunction

    function automatic void add_row(logic [7:0] c, bit e, bit typed, token_t t);
        row_t r;
        r.ch = c;
        r.e = e;
        r.typed = typed;
        r.tok = t;
        rows.push_back(r);
    endfunction

    function automatic void add_plain(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            add_row(s[i], 1'b0, 1'b0, '0);
        end
    endfunction

    // token side: random ready, checking, watchdog
    always @(posedge clk)
    begin
        token_t want;
        tx_accept = tv.valid && tv.ready;
        if (rst_n && tx_accept)
        begin
            if (token_q.size() == 0)
            begin
                report("unexpected token kind", tv.token_kind, 0);
            end
            else
            begin
                want = token_q.pop_front();
                if (tv.token_kind !== want.kind)
                    report("token_kind", tv.token_kind, want.kind);
                if (tv.sub_code !== want.sub)
                    report("sub_code", tv.sub_code, want.sub);
                if (tv.lexeme_byte !== want.lex_byte)
                    report("lexeme_byte", tv.lexeme_byte, want.lex_byte);
                if (tv.int_value !== want.ival)
                    report("int_value", tv.int_value, want.ival);
                if (tv.line_number !== want.line)
                    report("line_number", tv.line_number, want.line);
                if (tv.run_last !== want.last)
                    report("run_last", tv.run_last, want.last);
            end
        end
        cycle_cnt++;
        tv.ready <= (cycle_cnt > 1500 && cycle_cnt < 2500) ||
                    ($urandom_range(99) >= IDLE_PCT);
        if (tx_accept || (cv.valid && cv.ready) || !rst_n)
        begin
            stall_cnt = 0;
        end
        else
        begin
            stall_cnt++;
        end
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("source_tokenizer verification failed");
            $finish;
        end
    end

    initial
    begin
        token_t none;
        none = '0;
        cv.valid = 1'b0;
        cv.char_code = 8'd0;
        cv.is_end = 1'b0;
        tv.ready = 1'b0;
        rst_n = 1'b0;
        errors = 0;
        items_sent = 0;
        stall_cnt = 0;
        cycle_cnt = 0;
        ph = PH_START;
        lex_cnt = 0;
        num_acc = '0;
        esc_acc = 0;
        lines_seen = '0;
        halted = 1'b0;

        // directed: single tokens typed in, lexeme runs left to the predictor
        add_row(8'd0, 1'b1, 1'b1, tk(K_EOF, SUB_NONE, 16'd0));
        add_row("+", 1'b0, 1'b1, tk(K_OPER, OP_ADD, 16'd0));
        add_row("*", 1'b0, 1'b1, tk(K_OPER, OP_MUL, 16'd0));
        add_row("#", 1'b0, 1'b1, tk(K_OPER, OP_LEN, 16'd0));
        add_row("[", 1'b0, 1'b1, tk(K_PUNCT, PU_OPEN, 16'd0));
        add_row(")", 1'b0, 1'b1, tk(K_PUNCT, PU_CLOSE, 16'd0));
        add_row(":", 1'b0, 1'b1, tk(K_PUNCT, PU_COLON, 16'd0));
        add_row(",", 1'b0, 1'b1, tk(K_PUNCT, PU_COMMA, 16'd0));
        add_row(8'd10, 1'b0, 1'b0, none);
        add_row("=", 1'b0, 1'b0, none);
        add_row("=", 1'b0, 1'b1, tk(K_OPER, OP_EQ, 16'd1));
        add_row("~", 1'b0, 1'b0, none);
        add_row("=", 1'b0, 1'b1, tk(K_OPER, OP_NE, 16'd1));
        add_row(".", 1'b0, 1'b0, none);
        add_row(".", 1'b0, 1'b1, tk(K_OPER, OP_CAT, 16'd1));
        add_row("\"", 1'b0, 1'b0, none);
        add_row("\"", 1'b0, 1'b1, tk(K_STRING, SUB_NONE, 16'd1));
        add_plain("2147483648 write do 1.5e-3\"\\255\\001\xff\"/");
        add_row(8'hff, 1'b1, 1'b0, none);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_byte(rows[i].ch, rows[i].e, rows[i].typed, rows[i].tok);
        end

        while (items_sent < ITEM_GOAL)
        begin
            gen_token();
            flush_src();
        end

        // one deliberate error, then the block must stay silent
        case ($urandom_range(2))
            0:       gen_ident(LEX_DEPTH + 1);
            1:       push_str("@");
            default: push_str("\"ab");
        endcase
        push_ch(" ");
        repeat (6) push_ch(8'($urandom_range(255)));
        flush_src();
        send_byte(8'd0, 1'b1, 1'b0, none);

        cv.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (token_q.size() != 0);
        repeat (60) @(posedge clk);

        if (errors == 0)
        begin
            $display("source_tokenizer verification clean");
        end
        else
        begin
            $display("source_tokenizer verification failed");
        end
        $finish;
    end

endmodule
